// ----- src/ita_pkg.sv -----
// Shared types, constants and digit lookup for the integer to ASCII formatter.
package ita_pkg;

	localparam int NUMBER_PORT_W = 32;
	localparam int RADIX_W = 5;
	localparam int CHAR_W = 7;
	localparam int DIGIT_W = 4;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;

	typedef struct packed {
		logic [NUMBER_PORT_W-1:0] number;
		logic [RADIX_W-1:0] radix;
	} number_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic last_digit;
	} digit_item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_READ,
		BK_SEND
	} back_state_t;

	typedef struct packed {
		logic job_pop;
		logic store_we;
		logic load_out;
	} back_ctl_t;

	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {3'b000, d};
		end else begin
			c = CHAR_UPPER_A + {3'b000, d} - 7'd10;
		end
		return c;
	endfunction

endpackage

// ----- src/integer_to_ascii_formatter_unit.sv -----
// Top level of the integer to ASCII formatter: front queue and division back end.
//
// channel   direction  handshake                   payload
// number    in         number_valid/number_stall   number_item (number, radix)
// digit     out        digit_valid/digit_stall     digit_item (digit_char, last_digit)
//
// In the back end each digit of an item takes a full pass of the one-bit-a-cycle restoring
// divider over the number; once all digits are stored, each is read from the digit store and
// loaded into the output register. Worst case at 32 bits is 32 digits.
// The front queue holds two items, so input is taken while a conversion runs.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stall on the digit channel holds the back end; the front keeps filling its queue.
module integer_to_ascii_formatter_unit #(
	parameter int NUMBER_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic number_valid,
	output logic number_stall,
	input ita_pkg::number_item_t number_item,
	output logic digit_valid,
	input logic digit_stall,
	output ita_pkg::digit_item_t digit_item
);

	logic job_valid;
	logic job_pop;
	logic [NUMBER_WIDTH-1:0] job_number;
	logic [ita_pkg::RADIX_W-1:0] job_radix;

	ita_front #(
		.QW(NUMBER_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.number_valid(number_valid),
		.number_stall(number_stall),
		.number_item(number_item),
		.job_valid(job_valid),
		.job_pop(job_pop),
		.job_number(job_number),
		.job_radix(job_radix)
	);

	ita_back #(
		.QW(NUMBER_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job_pop(job_pop),
		.job_number(job_number),
		.job_radix(job_radix),
		.digit_valid(digit_valid),
		.digit_stall(digit_stall),
		.digit_item(digit_item)
	);

endmodule

// ----- src/ita_front.sv -----
// Front end: accepts items, clamps the radix, and queues jobs for the back end.
module ita_front #(
	parameter int QW = 32
) (
	input logic clk,
	input logic arst_n,
	input logic number_valid,
	output logic number_stall,
	input ita_pkg::number_item_t number_item,
	output logic job_valid,
	input logic job_pop,
	output logic [QW-1:0] job_number,
	output logic [ita_pkg::RADIX_W-1:0] job_radix
);

	localparam int DEPTH = 2;

	logic [QW-1:0] num_q [DEPTH];
	logic [ita_pkg::RADIX_W-1:0] rad_q [DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	logic pop;
	logic [63:0] num_ext;
	logic [ita_pkg::RADIX_W-1:0] rad_sat;

	assign number_stall = (count_q == 2'(DEPTH));
	assign push = number_valid && !number_stall;
	assign pop = job_pop && job_valid;
	assign job_valid = (count_q != 2'd0);
	assign job_number = num_q[rd_ptr_q];
	assign job_radix = rad_q[rd_ptr_q];

	always_comb begin
		num_ext = {32'd0, number_item.number};
		if (number_item.radix < ita_pkg::RADIX_MIN) begin
			rad_sat = ita_pkg::RADIX_MIN;
		end else if (number_item.radix > ita_pkg::RADIX_MAX) begin
			rad_sat = ita_pkg::RADIX_MAX;
		end else begin
			rad_sat = number_item.radix;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			num_q[wr_ptr_q] <= num_ext[QW-1:0];
			rad_q[wr_ptr_q] <= rad_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(DEPTH))
		else $error("queue count above depth");

	a_radix_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> (job_radix >= ita_pkg::RADIX_MIN && job_radix <= ita_pkg::RADIX_MAX))
		else $error("queued radix out of range");

	a_full_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'(DEPTH)) && !pop |=> count_q == 2'(DEPTH))
		else $error("full queue changed without pop");

endmodule

// ----- src/ita_back.sv -----
// Back end: bit-serial division into a digit store, then most significant first emission.
module ita_back #(
	parameter int QW = 32
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_pop,
	input logic [QW-1:0] job_number,
	input logic [ita_pkg::RADIX_W-1:0] job_radix,
	output logic digit_valid,
	input logic digit_stall,
	output ita_pkg::digit_item_t digit_item
);

	localparam int AW = (QW > 1) ? $clog2(QW) : 1;
	localparam int CW = $clog2(QW + 1);
	localparam int BW = $clog2(QW);

	ita_pkg::back_state_t st_q;
	ita_pkg::back_state_t st_n;
	ita_pkg::back_ctl_t ctl;

	logic [QW-1:0] quot_q;
	logic [ita_pkg::RADIX_W-1:0] rem_q;
	logic [ita_pkg::RADIX_W-1:0] radix_q;
	logic [BW-1:0] bit_cnt_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] rd_idx_q;
	logic [ita_pkg::DIGIT_W-1:0] rdata_q;
	logic [ita_pkg::DIGIT_W-1:0] digit_store_q [QW];
	logic out_valid_q;
	ita_pkg::digit_item_t out_q;

	logic [ita_pkg::RADIX_W-1:0] rem_sh;
	logic ge;
	logic [ita_pkg::RADIX_W-1:0] rem_n;
	logic [QW-1:0] quot_n;
	logic last_bit;
	logic out_free;

	always_comb begin
		rem_sh = {rem_q[ita_pkg::RADIX_W-2:0], quot_q[QW-1]};
		ge = (rem_sh >= radix_q);
		rem_n = ge ? (rem_sh - radix_q) : rem_sh;
		quot_n = {quot_q[QW-2:0], ge};
		last_bit = (bit_cnt_q == BW'(QW - 1));
		out_free = !out_valid_q || !digit_stall;
	end

	always_comb begin
		st_n = st_q;
		case (st_q)
			ita_pkg::BK_IDLE: begin
				if (job_valid) begin
					st_n = ita_pkg::BK_DIV;
				end
			end
			ita_pkg::BK_DIV: begin
				if (last_bit && (quot_n == '0)) begin
					st_n = ita_pkg::BK_READ;
				end
			end
			ita_pkg::BK_READ: begin
				st_n = ita_pkg::BK_SEND;
			end
			ita_pkg::BK_SEND: begin
				if (out_free) begin
					st_n = (rd_idx_q == '0) ? ita_pkg::BK_IDLE : ita_pkg::BK_READ;
				end
			end
			default: begin
				st_n = ita_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		case (st_q)
			ita_pkg::BK_IDLE: ctl.job_pop = job_valid;
			ita_pkg::BK_DIV: ctl.store_we = last_bit;
			ita_pkg::BK_SEND: ctl.load_out = out_free;
			default: ctl = '0;
		endcase
	end

	assign job_pop = ctl.job_pop;
	assign digit_valid = out_valid_q;
	assign digit_item = out_q;

	always_ff @(posedge clk) begin
		if (ctl.store_we) begin
			digit_store_q[cnt_q[AW-1:0]] <= rem_n[ita_pkg::DIGIT_W-1:0];
		end
		if (st_q == ita_pkg::BK_READ) begin
			rdata_q <= digit_store_q[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.job_pop) begin
			radix_q <= job_radix;
		end
		if (ctl.load_out) begin
			out_q.digit_char <= ita_pkg::digit_ascii(rdata_q);
			out_q.last_digit <= (rd_idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ita_pkg::BK_IDLE;
			quot_q <= '0;
			rem_q <= '0;
			bit_cnt_q <= '0;
			cnt_q <= '0;
			rd_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (ctl.job_pop) begin
				quot_q <= job_number;
				rem_q <= '0;
				bit_cnt_q <= '0;
				cnt_q <= '0;
			end else if (st_q == ita_pkg::BK_DIV) begin
				quot_q <= quot_n;
				if (last_bit) begin
					rem_q <= '0;
					bit_cnt_q <= '0;
					cnt_q <= cnt_q + CW'(1);
					rd_idx_q <= cnt_q[AW-1:0];
				end else begin
					rem_q <= rem_n;
					bit_cnt_q <= bit_cnt_q + BW'(1);
				end
			end else if (ctl.load_out && (rd_idx_q != '0)) begin
				rd_idx_q <= rd_idx_q - AW'(1);
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!digit_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QW))
		else $error("digit count above store depth");

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ita_pkg::BK_DIV) |-> rem_q < radix_q)
		else $error("partial remainder not below radix");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> ((out_q.digit_char >= 7'h30 && out_q.digit_char <= 7'h39)
			|| (out_q.digit_char >= 7'h41 && out_q.digit_char <= 7'h46)))
		else $error("digit character outside 0-9 and A-F");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> st_q == ita_pkg::BK_DIV)
		else $error("job taken without starting division");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the integer to ASCII formatter unit.
`timescale 1ns / 1ps

module testbench;

	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_CYCLES = 1200;
	localparam string GLYPHS = "0123456789ABCDEF";

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic number_valid = 1'b0;
	logic number_stall;
	ita_pkg::number_item_t number_item = '0;
	logic digit_valid;
	logic digit_stall = 1'b0;
	ita_pkg::digit_item_t digit_item;

	ita_pkg::digit_item_t expected_digits[$];
	int error_count = 0;
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	logic hold_request = 1'b0;
	int hold_left = 0;

	integer_to_ascii_formatter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.number_valid(number_valid),
		.number_stall(number_stall),
		.number_item(number_item),
		.digit_valid(digit_valid),
		.digit_stall(digit_stall),
		.digit_item(digit_item)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic void expand_digits(input ita_pkg::number_item_t item);
		logic [ita_pkg::RADIX_W-1:0] base;
		logic [ita_pkg::NUMBER_PORT_W-1:0] rest;
		logic [ita_pkg::DIGIT_W-1:0] remainders[ita_pkg::NUMBER_PORT_W];
		int count;
		ita_pkg::digit_item_t glyph;
		base = item.radix;
		if (base < ita_pkg::RADIX_MIN) begin
			base = ita_pkg::RADIX_MIN;
		end else if (base > ita_pkg::RADIX_MAX) begin
			base = ita_pkg::RADIX_MAX;
		end
		rest = item.number;
		count = 0;
		do begin
			remainders[count] = ita_pkg::DIGIT_W'(rest % base);
			rest = rest / base;
			count++;
		end while (rest != 0);
		for (int k = count - 1; k >= 0; k--) begin
			glyph.digit_char = ita_pkg::CHAR_W'(GLYPHS[remainders[k]]);
			glyph.last_digit = (k == 0);
			expected_digits.push_back(glyph);
		end
	endfunction

	always @(posedge clk) begin : scoreboard
		ita_pkg::digit_item_t want;
		if (arst_n && digit_valid && !digit_stall) begin
			if (expected_digits.size() == 0) begin
				report_mismatch($sformatf("unexpected character %h last %b",
					digit_item.digit_char, digit_item.last_digit));
			end else begin
				want = expected_digits.pop_front();
				if (digit_item.digit_char !== want.digit_char) begin
					report_mismatch($sformatf("digit_char %h, want %h",
						digit_item.digit_char, want.digit_char));
				end
				if (digit_item.last_digit !== want.last_digit) begin
					report_mismatch($sformatf("last_digit %b, want %b",
						digit_item.last_digit, want.last_digit));
				end
			end
		end
		if (arst_n && number_valid && !number_stall) begin
			expand_digits(number_item);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			digit_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_request) begin
			hold_left <= HOLD_CYCLES;
			digit_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			digit_stall <= 1'b1;
		end else begin
			digit_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	task automatic send_number(input logic [ita_pkg::NUMBER_PORT_W-1:0] value,
			input logic [ita_pkg::RADIX_W-1:0] base);
		ita_pkg::number_item_t item;
		item.number = value;
		item.radix = base;
		number_valid <= 1'b1;
		number_item <= item;
		@(posedge clk);
		while (number_stall) @(posedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			number_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		sender_idle_pct = tx_pct;
		receiver_idle_pct <= rx_pct;
	endtask

	task automatic test_digit_extremes();
		send_number(32'd0, 5'd10);
		send_number(32'd0, 5'd2);
		send_number(32'd1, 5'd2);
		send_number(32'hFFFF_FFFF, 5'd2);
		send_number(32'hFFFF_FFFF, 5'd16);
		send_number(32'hFFFF_FFFF, 5'd10);
		send_number(32'hFFFF_FFFF, 5'd3);
		send_number(32'h8000_0000, 5'd2);
		send_number(32'hFEDC_BA98, 5'd16);
		send_number(32'h0123_4567, 5'd16);
		send_number(32'h0000_000F, 5'd16);
		send_number(32'd9, 5'd10);
		send_number(32'd10, 5'd10);
	endtask

	task automatic test_radix_saturation();
		send_number(32'd0, 5'd0);
		send_number(32'd5, 5'd0);
		send_number(32'd5, 5'd1);
		send_number(32'hFFFF_FFFF, 5'd1);
		send_number(32'd255, 5'd17);
		send_number(32'hFFFF_FFFF, 5'd31);
		send_number(32'd0, 5'd31);
		send_number(32'd12345, 5'd20);
	endtask

	task automatic test_random_numbers(input int count);
		logic [ita_pkg::NUMBER_PORT_W-1:0] value;
		logic [ita_pkg::RADIX_W-1:0] base;
		int span;
		repeat (count) begin
			span = $urandom_range(ita_pkg::NUMBER_PORT_W, 1);
			value = $urandom;
			if (span < ita_pkg::NUMBER_PORT_W) begin
				value = value & ((32'd1 << span) - 32'd1);
			end
			if ($urandom_range(9) == 0) begin
				base = ita_pkg::RADIX_W'($urandom_range(31, 0));
			end else begin
				base = ita_pkg::RADIX_W'($urandom_range(16, 2));
			end
			send_number(value, base);
		end
	endtask

	task automatic test_output_backpressure();
		number_valid <= 1'b0;
		hold_request <= 1'b1;
		@(posedge clk);
		hold_request <= 1'b0;
		repeat (6) begin
			send_number(32'($urandom_range(4095)), 5'd16);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(29, 69);
		test_digit_extremes();
		test_radix_saturation();
		test_random_numbers(125);

		set_idling(69, 29);
		test_random_numbers(125);

		set_idling(0, 0);
		test_output_backpressure();
		test_random_numbers(125);

		number_valid <= 1'b0;
		while (expected_digits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
src/ita_pkg.sv
src/ita_front.sv
src/ita_back.sv
src/integer_to_ascii_formatter_unit.sv
test/testbench.sv
